FILE: src/ddo_pkg.sv
// Shared types and constants for the differential-drive odometry block.
package ddo_pkg;

   localparam int CORDIC_STEPS    = 16;
   // rotations per pipeline stage, four rotation stages in all
   localparam int STEPS_PER_STAGE = 4;

   localparam logic signed [17:0] CORDIC_START = 18'sd19899;
   localparam logic signed [17:0] Q15_LIMIT    = 18'sd32767;
   localparam logic signed [17:0] QUARTER_TURN = 18'sd16384;
   localparam logic signed [17:0] HALF_TURN    = 18'sd32768;

   localparam logic signed [17:0] ATAN_TABLE [CORDIC_STEPS] = '{
      18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163, 18'sd81,
      18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1, 18'sd0
   };

   typedef struct packed {
      logic signed [31:0] left_count;
      logic signed [31:0] right_count;
      logic [15:0]        yaw_angle;
      logic               zero_encoders;
      logic               zero_heading;
      logic               zero_position;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic [15:0]        heading_rel;
      logic signed [31:0] left_distance;
      logic signed [31:0] right_distance;
   } rsp_type;

   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [17:0] z;
   } cordic_type;

   typedef struct packed {
      logic               zero_position;
      logic [15:0]        heading_rel;
      logic signed [31:0] left_distance;
      logic signed [31:0] right_distance;
   } carry_type;

endpackage

FILE: src/ddo_req_if.sv
// Sample channel: valid, ready and one odometry input item.
interface ddo_req_if;
   logic              valid;
   logic              ready;
   ddo_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/ddo_rsp_if.sv
// Result channel: valid, ready and one odometry result item.
interface ddo_rsp_if;
   logic              valid;
   logic              ready;
   ddo_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/diff_drive_odometry.sv
// Differential-drive dead-reckoning odometry, top level.
// Takes one sample item per cycle while the pipeline is not held by a stalled result, and
// returns one result item per sample. Stage one applies encoder and heading zeroing and
// forms relative counts, heading and the mean delta; stages two to five run four CORDIC
// rotations each for cosine and sine of the heading, stage five also undoing the half-turn
// fold and saturating; stage six forms the two 32 x 16 products; the result register adds
// them into the x and y accumulators, clearing them first on position zeroing. Each stage
// holds while the one after it is full and stalled, so bubbles are squeezed out and
// sampling continues while a result waits.
module diff_drive_odometry (
   input  logic         clock,
   input  logic         reset,
   ddo_req_if.sink      req_port,
   ddo_rsp_if.source    rsp_port
);

   function automatic ddo_pkg::cordic_type cordic_part(ddo_pkg::cordic_type v, int base);
      ddo_pkg::cordic_type r;
      logic signed [17:0]  xs;
      logic signed [17:0]  ys;
      r = v;
      for (int i = 0; i < ddo_pkg::STEPS_PER_STAGE; i++) begin
         xs = r.x >>> (base + i);
         ys = r.y >>> (base + i);
         if (r.z >= 0) begin
            r.x = r.x - ys;
            r.y = r.y + xs;
            r.z = r.z - ddo_pkg::ATAN_TABLE[base + i];
         end else begin
            r.x = r.x + ys;
            r.y = r.y - xs;
            r.z = r.z + ddo_pkg::ATAN_TABLE[base + i];
         end
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat_q15(logic signed [17:0] v);
      logic signed [17:0] r;
      r = v;
      if (v > ddo_pkg::Q15_LIMIT) r = ddo_pkg::Q15_LIMIT;
      if (v < -ddo_pkg::Q15_LIMIT) r = -ddo_pkg::Q15_LIMIT;
      return r[15:0];
   endfunction

   // zeroing and running state
   logic [31:0] left_offset_ff, right_offset_ff, last_left_ff, last_right_ff;
   logic [15:0] heading_offset_ff;
   logic signed [47:0] x_accum_ff, y_accum_ff;

   // stage registers
   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic signed [31:0]  mean1_ff, mean2_ff, mean3_ff, mean4_ff, mean5_ff;
   logic                flip1_ff, flip2_ff, flip3_ff, flip4_ff;
   ddo_pkg::cordic_type cord1_ff, cord2_ff, cord3_ff, cord4_ff;
   logic signed [15:0]  cos5_ff, sin5_ff;
   logic signed [47:0]  px6_ff, py6_ff;
   ddo_pkg::carry_type  carry1_ff, carry2_ff, carry3_ff, carry4_ff, carry5_ff, carry6_ff;
   ddo_pkg::rsp_type    rsp_payload_ff;

   logic r1, r2, r3, r4, r5, r6, out_ready, accept;

   // stage one combinational
   logic [31:0]         left_offset_in, right_offset_in, last_left_use, last_right_use;
   logic [15:0]         heading_offset_in;
   logic [31:0]         lrel, rrel, dl, dr;
   logic [15:0]         hrel;
   logic signed [32:0]  delta_sum;
   logic signed [32:0]  mean_wide;
   logic signed [17:0]  angle;
   logic signed [17:0]  angle_fold;
   logic                flip;

   // later stages
   ddo_pkg::cordic_type cord_a, cord_b, cord_c, cord_end;
   logic signed [17:0]  cx, cy;
   logic signed [47:0]  px, py;
   logic signed [47:0]  x_accum_in, y_accum_in;

   assign out_ready      = !rsp_valid_ff || rsp_port.ready;
   assign r6             = !v6_ff || out_ready;
   assign r5             = !v5_ff || r6;
   assign r4             = !v4_ff || r5;
   assign r3             = !v3_ff || r4;
   assign r2             = !v2_ff || r3;
   assign r1             = !v1_ff || r2;
   assign req_port.ready = r1;
   assign accept         = req_port.valid && r1;

   always_comb begin
      left_offset_in    = left_offset_ff;
      right_offset_in   = right_offset_ff;
      last_left_use     = last_left_ff;
      last_right_use    = last_right_ff;
      heading_offset_in = heading_offset_ff;
      if (req_port.payload.zero_encoders) begin
         left_offset_in  = req_port.payload.left_count;
         right_offset_in = req_port.payload.right_count;
         last_left_use   = '0;
         last_right_use  = '0;
      end
      if (req_port.payload.zero_heading) begin
         heading_offset_in = req_port.payload.yaw_angle;
      end
      lrel      = req_port.payload.left_count - left_offset_in;
      rrel      = req_port.payload.right_count - right_offset_in;
      hrel      = req_port.payload.yaw_angle - heading_offset_in;
      dl        = lrel - last_left_use;
      dr        = rrel - last_right_use;
      delta_sum = $signed({dl[31], dl}) + $signed({dr[31], dr});
      // halve, truncating toward zero
      mean_wide = (delta_sum + $signed({32'd0, delta_sum[32]})) >>> 1;
      angle     = $signed({{2{hrel[15]}}, hrel});
      angle_fold = angle;
      flip       = 1'b0;
      if (angle > ddo_pkg::QUARTER_TURN) begin
         angle_fold = angle - ddo_pkg::HALF_TURN;
         flip       = 1'b1;
      end else if (angle < -ddo_pkg::QUARTER_TURN) begin
         angle_fold = angle + ddo_pkg::HALF_TURN;
         flip       = 1'b1;
      end
   end

   always_comb begin
      cord_a     = cordic_part(cord1_ff, 0);
      cord_b     = cordic_part(cord2_ff, ddo_pkg::STEPS_PER_STAGE);
      cord_c     = cordic_part(cord3_ff, 2 * ddo_pkg::STEPS_PER_STAGE);
      cord_end   = cordic_part(cord4_ff, 3 * ddo_pkg::STEPS_PER_STAGE);
      cx         = flip4_ff ? -cord_end.x : cord_end.x;
      cy         = flip4_ff ? -cord_end.y : cord_end.y;
      px         = 48'(mean5_ff) * 48'(cos5_ff);
      py         = 48'(mean5_ff) * 48'(sin5_ff);
      x_accum_in = (carry6_ff.zero_position ? 48'sd0 : x_accum_ff) + px6_ff;
      y_accum_in = (carry6_ff.zero_position ? 48'sd0 : y_accum_ff) + py6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_offset_ff    <= '0;
         right_offset_ff   <= '0;
         last_left_ff      <= '0;
         last_right_ff     <= '0;
         heading_offset_ff <= '0;
         x_accum_ff        <= '0;
         y_accum_ff        <= '0;
         v1_ff             <= 1'b0;
         v2_ff             <= 1'b0;
         v3_ff             <= 1'b0;
         v4_ff             <= 1'b0;
         v5_ff             <= 1'b0;
         v6_ff             <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            left_offset_ff    <= left_offset_in;
            right_offset_ff   <= right_offset_in;
            heading_offset_ff <= heading_offset_in;
            last_left_ff      <= lrel;
            last_right_ff     <= rrel;
         end
         if (r1) v1_ff <= req_port.valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= v4_ff;
         if (r6) v6_ff <= v5_ff;
         if (out_ready) begin
            rsp_valid_ff <= v6_ff;
            if (v6_ff) begin
               x_accum_ff <= x_accum_in;
               y_accum_ff <= y_accum_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         mean1_ff                 <= mean_wide[31:0];
         flip1_ff                 <= flip;
         cord1_ff.x               <= ddo_pkg::CORDIC_START;
         cord1_ff.y               <= '0;
         cord1_ff.z               <= angle_fold;
         carry1_ff.zero_position  <= req_port.payload.zero_position;
         carry1_ff.heading_rel    <= hrel;
         carry1_ff.left_distance  <= lrel;
         carry1_ff.right_distance <= rrel;
      end
      if (r2) begin
         mean2_ff  <= mean1_ff;
         flip2_ff  <= flip1_ff;
         cord2_ff  <= cord_a;
         carry2_ff <= carry1_ff;
      end
      if (r3) begin
         mean3_ff  <= mean2_ff;
         flip3_ff  <= flip2_ff;
         cord3_ff  <= cord_b;
         carry3_ff <= carry2_ff;
      end
      if (r4) begin
         mean4_ff  <= mean3_ff;
         flip4_ff  <= flip3_ff;
         cord4_ff  <= cord_c;
         carry4_ff <= carry3_ff;
      end
      if (r5) begin
         mean5_ff  <= mean4_ff;
         cos5_ff   <= sat_q15(cx);
         sin5_ff   <= sat_q15(cy);
         carry5_ff <= carry4_ff;
      end
      if (r6) begin
         px6_ff    <= px;
         py6_ff    <= py;
         carry6_ff <= carry5_ff;
      end
      if (out_ready && v6_ff) begin
         rsp_payload_ff.pos_x          <= x_accum_in;
         rsp_payload_ff.pos_y          <= y_accum_in;
         rsp_payload_ff.heading_rel    <= carry6_ff.heading_rel;
         rsp_payload_ff.left_distance  <= carry6_ff.left_distance;
         rsp_payload_ff.right_distance <= carry6_ff.right_distance;
      end
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_payload_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted item did not reach stage one");

   a_last_moves_out: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && out_ready) |=> rsp_valid_ff)
      else $error("finished item lost before the result register");

   a_accum_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_port.ready) |=> ($stable(x_accum_ff) && $stable(y_accum_ff)))
      else $error("accumulator moved while result stalled");

   a_zero_position: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && out_ready && carry6_ff.zero_position)
         |=> (rsp_port.payload.pos_x == $past(px6_ff)
              && rsp_port.payload.pos_y == $past(py6_ff)))
      else $error("position zeroing not applied");

endmodule

FILE: verif/ddo_tb_pkg.sv
`timescale 1ns / 100ps
// Pose scoreboard for the odometry testbench: predicts each result and checks it.
package ddo_tb_pkg;

   localparam int ROT_STEPS = 16;
   localparam int ROT_START = 19899;
   localparam int Q15_MAX   = 32767;
   localparam int QUARTER   = 16384;
   localparam int HALF      = 32768;
   localparam int ROT_ANGLE [ROT_STEPS] = '{
      8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
   };
   localparam int MAX_REPORTS = 10;

   class pose_scoreboard;
      logic [31:0] left_zero;
      logic [31:0] right_zero;
      logic [15:0] yaw_zero;
      logic [31:0] prev_left;
      logic [31:0] prev_right;
      logic [47:0] x_sum;
      logic [47:0] y_sum;
      ddo_pkg::rsp_type pending_poses [$];
      int unsigned mismatches;

      function new();
         left_zero  = '0;
         right_zero = '0;
         yaw_zero   = '0;
         prev_left  = '0;
         prev_right = '0;
         x_sum      = '0;
         y_sum      = '0;
         mismatches = 0;
      endfunction

      // rotation-mode CORDIC, angle folded into the right half-plane first
      static function void cordic_sincos(input logic [15:0] angle, output int cos_q15,
                                         output int sin_q15);
         int a;
         int x;
         int y;
         int z;
         int xs;
         int ys;
         bit flip;
         a = int'($signed(angle));
         flip = 1'b0;
         if (a > QUARTER) begin
            a -= HALF;
            flip = 1'b1;
         end else if (a < -QUARTER) begin
            a += HALF;
            flip = 1'b1;
         end
         x = ROT_START;
         y = 0;
         z = a;
         for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys;
               y += xs;
               z -= ROT_ANGLE[i];
            end else begin
               x += ys;
               y -= xs;
               z += ROT_ANGLE[i];
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         cos_q15 = (x > Q15_MAX) ? Q15_MAX : (x < -Q15_MAX) ? -Q15_MAX : x;
         sin_q15 = (y > Q15_MAX) ? Q15_MAX : (y < -Q15_MAX) ? -Q15_MAX : y;
      endfunction

      function void note_sample(input ddo_pkg::req_type s);
         logic [31:0] lrel;
         logic [31:0] rrel;
         logic [31:0] dl;
         logic [31:0] dr;
         logic [15:0] hrel;
         longint      mean;
         int          c;
         int          sn;
         ddo_pkg::rsp_type p;
         if (s.zero_encoders) begin
            left_zero  = s.left_count;
            right_zero = s.right_count;
            prev_left  = '0;
            prev_right = '0;
         end
         if (s.zero_heading)
            yaw_zero = s.yaw_angle;
         if (s.zero_position) begin
            x_sum = '0;
            y_sum = '0;
         end
         lrel = s.left_count - left_zero;
         rrel = s.right_count - right_zero;
         hrel = s.yaw_angle - yaw_zero;
         dl   = lrel - prev_left;
         dr   = rrel - prev_right;
         mean = (longint'($signed(dl)) + longint'($signed(dr))) / 2;
         cordic_sincos(hrel, c, sn);
         x_sum = x_sum + 48'(mean * longint'(c));
         y_sum = y_sum + 48'(mean * longint'(sn));
         prev_left  = lrel;
         prev_right = rrel;
         p.pos_x          = x_sum;
         p.pos_y          = y_sum;
         p.heading_rel    = hrel;
         p.left_distance  = lrel;
         p.right_distance = rrel;
         pending_poses.push_back(p);
      endfunction

      function void compare_field(input string name, input logic [47:0] want,
                                  input logic [47:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch on %s: expected %h, got %h", name, want, got);
         end
      endfunction

      function void check_pose(input ddo_pkg::rsp_type got);
         ddo_pkg::rsp_type want;
         if (pending_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result item: x %h y %h heading %h", got.pos_x,
                        got.pos_y, got.heading_rel);
            return;
         end
         want = pending_poses.pop_front();
         compare_field("pos_x", want.pos_x, got.pos_x);
         compare_field("pos_y", want.pos_y, got.pos_y);
         compare_field("heading_rel", 48'(want.heading_rel), 48'(got.heading_rel));
         compare_field("left_distance", 48'(want.left_distance), 48'(got.left_distance));
         compare_field("right_distance", 48'(want.right_distance),
                       48'(got.right_distance));
      endfunction
   endclass

endpackage

FILE: verif/diff_drive_odometry_tb.sv
`timescale 1ns / 100ps
// Testbench top for the odometry block: directed and random samples, checked per item.
module diff_drive_odometry_tb;

   localparam logic [2:0] ZERO_NONE = 3'b000;
   localparam logic [2:0] ZERO_POS  = 3'b001;
   localparam logic [2:0] ZERO_HDG  = 3'b010;
   localparam logic [2:0] ZERO_ENC  = 3'b100;
   localparam logic [2:0] ZERO_ALL  = 3'b111;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;
   bit   no_gaps;
   int   cycles;

   ddo_req_if req_ch ();
   ddo_rsp_if rsp_ch ();

   ddo_tb_pkg::pose_scoreboard sb = new();

   diff_drive_odometry u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ch.ready = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_pose(rsp_ch.payload);
         if (req_ch.valid && req_ch.ready)
            sb.note_sample(req_ch.payload);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // entered and left at a falling edge; valid stays high between back-to-back items
   task automatic send_sample(input logic [31:0] lc, input logic [31:0] rc,
                              input logic [15:0] yaw, input logic [2:0] flags);
      ddo_pkg::req_type s;
      while (!no_gaps && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      s.left_count    = lc;
      s.right_count   = rc;
      s.yaw_angle     = yaw;
      s.zero_encoders = flags[2];
      s.zero_heading  = flags[1];
      s.zero_position = flags[0];
      req_ch.valid   <= 1'b1;
      req_ch.payload <= s;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] lcnt;
      logic [31:0] rcnt;
      logic [15:0] yaw;
      logic [2:0]  flags;
      int          pick;
      logic [15:0] sweep [10];
      sweep = '{16'h8000, 16'h4001, 16'hBFFF, 16'hC000, 16'h3FFF,
                16'hFFFF, 16'h0001, 16'h7FFF, 16'h8001, 16'h4000};
      cycles         = 0;
      no_gaps        = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_sample(32'h0000_0000, 32'h0000_0000, 16'h0000, ZERO_ALL);
      // full-scale forward step, cosine saturates at zero heading
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, ZERO_NONE);
      send_sample(32'h8000_0000, 32'h8000_0000, 16'hFFFF, ZERO_NONE);
      send_sample(32'h0000_0000, 32'hFFFF_FFFF, 16'h8000, ZERO_NONE);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'h4000, ZERO_NONE);
      // odd negative sum, mean truncates toward zero
      send_sample(32'h7FFF_FFFC, 32'h8000_0000, 16'h4001, ZERO_NONE);
      lcnt = 32'h7FFF_FFFC;
      rcnt = 32'h8000_0000;
      foreach (sweep[i]) begin
         lcnt += 5000;
         rcnt += 3001;
         send_sample(lcnt, rcnt, sweep[i], ZERO_NONE);
      end
      send_sample(lcnt + 100, rcnt + 200, 16'h1234, ZERO_HDG);
      send_sample(lcnt + 300, rcnt + 300, 16'h2345, ZERO_POS);
      send_sample(32'hFFFF_FFFF, 32'h8000_0001, 16'h3456, ZERO_ENC);
      // repeated full-scale steps wrap the accumulators
      lcnt = 32'h0;
      rcnt = 32'h0;
      yaw  = 16'h2000;
      send_sample(lcnt, rcnt, yaw, ZERO_ALL);
      repeat (5) begin
         lcnt += 32'h7FFF_FFFF;
         rcnt += 32'h7FFF_FFFF;
         send_sample(lcnt, rcnt, yaw, ZERO_NONE);
      end
      // most negative mean
      lcnt += 32'h8000_0000;
      rcnt += 32'h8000_0000;
      send_sample(lcnt, rcnt, yaw, ZERO_NONE);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_gaps = (n >= 500 && n < 800);
         pick = $urandom_range(99);
         if (pick < 70) begin
            lcnt += $urandom_range(4000) - 2000;
            rcnt += $urandom_range(4000) - 2000;
            yaw  += 16'($urandom_range(600) - 300);
            flags = {$urandom_range(99) < 2, $urandom_range(99) < 2, $urandom_range(99) < 2};
         end else if (pick < 85) begin
            lcnt += $urandom;
            rcnt += $urandom;
            yaw   = 16'($urandom_range(65535));
            flags = ZERO_NONE;
         end else begin
            lcnt  = $urandom;
            rcnt  = $urandom;
            yaw   = 16'($urandom_range(65535));
            flags = 3'($urandom_range(7));
         end
         send_sample(lcnt, rcnt, yaw, flags);
      end
      req_ch.valid <= 1'b0;

      while (sb.pending_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_poses.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: files.f
src/ddo_pkg.sv
src/ddo_req_if.sv
src/ddo_rsp_if.sv
src/diff_drive_odometry.sv
verif/ddo_tb_pkg.sv
verif/diff_drive_odometry_tb.sv
